### sv/ddo_pkg.sv
// Shared types, constants and tables for the differential-drive odometry block.
`default_nettype none

package ddo_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WHEEL_SIZE  = 2'd0;
    localparam logic [1:0] REG_AXLE_SPAN   = 2'd1;
    localparam logic [1:0] REG_COUNTS_REV  = 2'd2;
    localparam logic [1:0] REG_MAX_RPM     = 2'd3;

    localparam logic [31:0] WHEEL_SIZE_RST  = 32'd65536;
    localparam logic [31:0] AXLE_SPAN_RST   = 32'd65536;
    localparam logic [15:0] COUNTS_REV_RST  = 16'd1024;
    localparam logic [15:0] MAX_RPM_RST     = 16'd3000;

    localparam logic [63:0] PI_Q29      = 64'd1686629713;
    localparam logic [63:0] NS_PER_S    = 64'd1000000000;
    localparam logic [63:0] NS_PER_MIN  = 64'd60000000000;
    localparam logic [63:0] HEADING_MUL = 64'd32768;

    // CORDIC start vector: 1/K in Q30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_POST,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_CMP
    } op_t;

    typedef enum logic [4:0] {
        ST_RPM_CPR,
        ST_LIM,
        ST_OVER_L,
        ST_CMP_L,
        ST_OVER_R,
        ST_CMP_R,
        ST_WS_SUM,
        ST_BASE1,
        ST_DS,
        ST_BASE1_NS,
        ST_V_CPR,
        ST_V_DT,
        ST_WS_DIFF,
        ST_T_PI,
        ST_T_NS,
        ST_T_TRK,
        ST_T_CPR,
        ST_T_DT,
        ST_H_MUL,
        ST_H_TRK,
        ST_H_CPR,
        ST_VX,
        ST_VY,
        ST_PX,
        ST_PY
    } step_t;

    // atan(2^-i) in units where 2^30 is a quarter turn
    function automatic logic [31:0] atan_entry(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2F9;
            default: v = 32'h0000517D;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/diff_drive_odometry.sv
// Differential-drive wheel odometry: sequenced shared multiply/divide unit plus CORDIC.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | left_count, right_count, timestamp_ns
//  out      | out_valid / out_stall | pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
//           |                       | overspeed, zero_interval
//  cfg      | APB psel/penable      | wheel_size, axle span, counts_per_rev, max_rpm
//
//  An item with a positive interval runs 15 shift-add multiplies, 8 restoring divides and
//  2 compares, all on one 129-bit adder, between being accepted and being delivered.
//  A zero or backward interval goes straight from acceptance to delivery.
//  The heading CORDIC runs its 16 steps alongside the first multiply.
//  Reset clears configuration to defaults, the pose and previous report to zero.
//  A stalled output holds its beat; the next input beat is taken while it waits.
`default_nettype none

module diff_drive_odometry #(
    parameter int FRAC_BITS = ddo_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] left_count,
    input  wire logic signed [31:0] right_count,
    input  wire logic        [62:0] timestamp_ns,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed      [31:0] pos_x,
    output logic signed      [31:0] pos_y,
    output logic signed      [15:0] heading,
    output logic signed      [31:0] vel_x,
    output logic signed      [31:0] vel_y,
    output logic signed      [31:0] turn_rate,
    output logic                    overspeed,
    output logic                    zero_interval,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [3:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    localparam int CPR_SHIFT = 29 - FRAC_BITS;

    // configuration
    logic [31:0] wheel_size_reg;
    logic [31:0] axle_span_reg;
    logic [15:0] counts_rev_reg;
    logic [15:0] max_rpm_reg;
    logic        cfg_wr;
    logic [15:0] cpr_eff;
    logic [31:0] trk_eff;

    // sequencer
    ddo_pkg::state_t state_reg, state_next;
    ddo_pkg::step_t  step_reg;
    logic [6:0]      cnt_reg;
    logic            accept;
    logic            out_free;
    logic            load_out;

    // persistent state
    logic signed [31:0] prev_left_reg;
    logic signed [31:0] prev_right_reg;
    logic        [62:0] prev_stamp_reg;
    logic        [31:0] pose_x_reg;
    logic        [31:0] pose_y_reg;
    logic        [15:0] pose_heading_reg;

    // per-item operands
    logic [32:0] dl_mag_reg, dr_mag_reg;
    logic [33:0] sum_mag_reg, diff_mag_reg;
    logic        sum_neg_reg, diff_neg_reg;
    logic [62:0] dt_reg;
    logic        zero_reg;

    // accept-cycle arithmetic
    logic signed [32:0] dl_w, dr_w;
    logic signed [33:0] sum_w, diff_w;
    logic               zero_w;

    // shared unit
    logic [127:0] acc_reg, mq_reg, xop_reg;
    logic [63:0]  rem_reg, dop_reg;
    logic [128:0] add_a, add_b, add_sum;
    logic         add_cin;
    logic         div_ge;
    ddo_pkg::op_t op_w;
    logic [127:0] x_w;
    logic [63:0]  y_w;
    logic         neg_w;
    logic [127:0] res_w;

    // results
    logic [127:0] lim_reg, base_reg, wd_reg;
    logic [32:0]  ds_mag_reg, v_mag_reg;
    logic [31:0]  vx_reg, vy_reg, turn_reg;
    logic         over_reg;
    logic [32:0]  clamp33_w;
    logic [31:0]  turn_w;
    logic [127:0] prod_s;
    logic signed [127:0] prod_sh;
    logic [31:0]  prod_sat;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg, ca_reg;
    logic               cflip_reg;
    logic [3:0]         cidx_reg;
    logic               crun_reg;
    logic signed [31:0] ua_s;
    logic               fold_w;
    logic signed [33:0] xs_w, ys_w, at_w;
    logic signed [33:0] c_w, s_w;
    logic               c_neg, s_neg;
    logic [31:0]        c_mag, s_mag;

    // output beat
    logic        out_valid_reg;
    logic [31:0] out_pos_x_reg, out_pos_y_reg, out_vel_x_reg, out_vel_y_reg, out_turn_reg;
    logic [15:0] out_heading_reg;
    logic        out_over_reg, out_zero_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign cpr_eff = (counts_rev_reg == 16'd0) ? 16'd1 : counts_rev_reg;
    assign trk_eff = (axle_span_reg == 32'd0) ? 32'd1 : axle_span_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            ddo_pkg::REG_WHEEL_SIZE:  prdata = wheel_size_reg;
            ddo_pkg::REG_AXLE_SPAN:   prdata = axle_span_reg;
            ddo_pkg::REG_COUNTS_REV:  prdata = {16'd0, counts_rev_reg};
            default:                  prdata = {16'd0, max_rpm_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_size_reg  <= ddo_pkg::WHEEL_SIZE_RST;
            axle_span_reg   <= ddo_pkg::AXLE_SPAN_RST;
            counts_rev_reg  <= ddo_pkg::COUNTS_REV_RST;
            max_rpm_reg     <= ddo_pkg::MAX_RPM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                ddo_pkg::REG_WHEEL_SIZE:  wheel_size_reg  <= pwdata;
                ddo_pkg::REG_AXLE_SPAN:   axle_span_reg   <= pwdata;
                ddo_pkg::REG_COUNTS_REV:  counts_rev_reg  <= pwdata[15:0];
                default:                  max_rpm_reg     <= pwdata[15:0];
            endcase
        end
    end

    // ---------------- accept-cycle deltas ----------------
    assign dl_w   = {left_count[31], left_count} - {prev_left_reg[31], prev_left_reg};
    assign dr_w   = {right_count[31], right_count} - {prev_right_reg[31], prev_right_reg};
    assign sum_w  = {dl_w[32], dl_w} + {dr_w[32], dr_w};
    assign diff_w = {dr_w[32], dr_w} - {dl_w[32], dl_w};
    assign zero_w = (timestamp_ns <= prev_stamp_reg);

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddo_pkg::S_IDLE:
                if (in_valid)
                    state_next = zero_w ? ddo_pkg::S_FINISH : ddo_pkg::S_SETUP;
            ddo_pkg::S_SETUP:
                state_next = (op_w == ddo_pkg::OP_CMP) ? ddo_pkg::S_POST : ddo_pkg::S_RUN;
            ddo_pkg::S_RUN:
                if (cnt_reg == 7'd0)
                    state_next = ddo_pkg::S_POST;
            ddo_pkg::S_POST:
                state_next = (step_reg == ddo_pkg::ST_PY) ? ddo_pkg::S_FINISH
                                                          : ddo_pkg::S_SETUP;
            ddo_pkg::S_FINISH:
                if (out_free)
                    state_next = ddo_pkg::S_IDLE;
            default:
                state_next = ddo_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ddo_pkg::S_IDLE);
        accept   = in_valid && (state_reg == ddo_pkg::S_IDLE);
        load_out = (state_reg == ddo_pkg::S_FINISH) && out_free;
    end

    // operands of each step
    always_comb
    begin
        op_w  = ddo_pkg::OP_MUL;
        x_w   = acc_reg;
        y_w   = 64'd0;
        neg_w = 1'b0;
        unique case (step_reg)
            ddo_pkg::ST_RPM_CPR:
            begin
                x_w = 128'(max_rpm_reg);
                y_w = 64'(cpr_eff);
            end
            ddo_pkg::ST_LIM:     y_w = 64'(dt_reg);
            ddo_pkg::ST_OVER_L:
            begin
                x_w = 128'(dl_mag_reg);
                y_w = ddo_pkg::NS_PER_MIN;
            end
            ddo_pkg::ST_CMP_L:   op_w = ddo_pkg::OP_CMP;
            ddo_pkg::ST_OVER_R:
            begin
                x_w = 128'(dr_mag_reg);
                y_w = ddo_pkg::NS_PER_MIN;
            end
            ddo_pkg::ST_CMP_R:   op_w = ddo_pkg::OP_CMP;
            ddo_pkg::ST_WS_SUM:
            begin
                x_w = 128'(wheel_size_reg);
                y_w = 64'(sum_mag_reg);
            end
            ddo_pkg::ST_BASE1:   y_w = ddo_pkg::PI_Q29;
            ddo_pkg::ST_DS:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = {18'd0, cpr_eff, 30'd0};
            end
            ddo_pkg::ST_BASE1_NS:
            begin
                x_w = base_reg;
                y_w = ddo_pkg::NS_PER_S;
            end
            ddo_pkg::ST_V_CPR:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = {18'd0, cpr_eff, 30'd0};
            end
            ddo_pkg::ST_V_DT:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = 64'(dt_reg);
            end
            ddo_pkg::ST_WS_DIFF:
            begin
                x_w = 128'(wheel_size_reg);
                y_w = 64'(diff_mag_reg);
            end
            ddo_pkg::ST_T_PI:    y_w = ddo_pkg::PI_Q29;
            ddo_pkg::ST_T_NS:    y_w = ddo_pkg::NS_PER_S;
            ddo_pkg::ST_T_TRK:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = 64'(trk_eff);
            end
            ddo_pkg::ST_T_CPR:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = 64'(cpr_eff) << CPR_SHIFT;
            end
            ddo_pkg::ST_T_DT:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = 64'(dt_reg);
            end
            ddo_pkg::ST_H_MUL:
            begin
                x_w = wd_reg;
                y_w = ddo_pkg::HEADING_MUL;
            end
            ddo_pkg::ST_H_TRK:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = 64'(trk_eff);
            end
            ddo_pkg::ST_H_CPR:
            begin
                op_w = ddo_pkg::OP_DIV;
                y_w  = 64'(cpr_eff);
            end
            ddo_pkg::ST_VX:
            begin
                x_w = 128'(v_mag_reg); y_w = 64'(c_mag); neg_w = sum_neg_reg ^ c_neg;
            end
            ddo_pkg::ST_VY:
            begin
                x_w = 128'(v_mag_reg); y_w = 64'(s_mag); neg_w = sum_neg_reg ^ s_neg;
            end
            ddo_pkg::ST_PX:
            begin
                x_w = 128'(ds_mag_reg); y_w = 64'(c_mag); neg_w = sum_neg_reg ^ c_neg;
            end
            ddo_pkg::ST_PY:
            begin
                x_w = 128'(ds_mag_reg); y_w = 64'(s_mag); neg_w = sum_neg_reg ^ s_neg;
            end
            default: op_w = ddo_pkg::OP_CMP;
        endcase
    end

    // ---------------- shared adder ----------------
    always_comb
    begin
        if (state_reg == ddo_pkg::S_POST)
        begin
            // lim - product: negative means the wheel ran too fast
            add_a   = {1'b0, lim_reg};
            add_b   = ~{1'b0, acc_reg};
            add_cin = 1'b1;
        end
        else if (op_w == ddo_pkg::OP_DIV)
        begin
            add_a   = {64'd0, rem_reg, mq_reg[127]};
            add_b   = ~{65'd0, dop_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = {1'b0, acc_reg[126:0], 1'b0};
            add_b   = {1'b0, mq_reg[63] ? xop_reg : 128'd0};
            add_cin = 1'b0;
        end
    end

    assign add_sum = add_a + add_b + 129'(add_cin);
    assign div_ge  = !add_sum[128];
    assign res_w   = (op_w == ddo_pkg::OP_DIV) ? mq_reg : acc_reg;

    // clamp to 2^32 for distance and speed
    assign clamp33_w = ((res_w[127:33] != '0) || (res_w[32] && (res_w[31:0] != 32'd0)))
                       ? 33'h1_0000_0000 : res_w[32:0];

    // turn rate magnitude limited to 2^31, then signed and saturated
    always_comb
    begin
        if (res_w[127:31] != '0)
            turn_w = diff_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            turn_w = diff_neg_reg ? (~res_w[31:0] + 32'd1) : res_w[31:0];
    end

    // signed product, floor-shifted by 30, saturated to 32 bits
    assign prod_s  = neg_w ? (~acc_reg + 128'd1) : acc_reg;
    assign prod_sh = $signed(prod_s) >>> 30;
    assign prod_sat = ((prod_sh[127:31] == '0) || (prod_sh[127:31] == '1)) ? prod_sh[31:0]
                      : (prod_sh[127] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // ---------------- CORDIC ----------------
    assign ua_s   = {pose_heading_reg, 16'd0};
    assign fold_w = (ua_s > 32'sh4000_0000) || (ua_s < -32'sh4000_0000);
    assign xs_w   = cx_reg >>> cidx_reg;
    assign ys_w   = cy_reg >>> cidx_reg;
    assign at_w   = $signed({2'b00, ddo_pkg::atan_entry(cidx_reg)});
    assign c_w    = cflip_reg ? -cx_reg : cx_reg;
    assign s_w    = cflip_reg ? -cy_reg : cy_reg;
    assign c_neg  = c_w[33];
    assign s_neg  = s_w[33];
    assign c_mag  = c_neg ? 32'(-c_w) : c_w[31:0];
    assign s_mag  = s_neg ? 32'(-s_w) : s_w[31:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg    <= ddo_pkg::CORDIC_X0;
            cy_reg    <= 34'sd0;
            ca_reg    <= fold_w ? $signed({{2{~ua_s[31]}}, ~ua_s[31], ua_s[30:0]})
                                : $signed({{2{ua_s[31]}}, ua_s});
            cflip_reg <= fold_w;
        end
        else if (crun_reg)
        begin
            if (!ca_reg[33])
            begin
                cx_reg <= cx_reg - ys_w;
                cy_reg <= cy_reg + xs_w;
                ca_reg <= ca_reg - at_w;
            end
            else
            begin
                cx_reg <= cx_reg + ys_w;
                cy_reg <= cy_reg - xs_w;
                ca_reg <= ca_reg + at_w;
            end
        end
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ddo_pkg::S_IDLE;
            step_reg         <= ddo_pkg::ST_RPM_CPR;
            cnt_reg          <= 7'd0;
            crun_reg         <= 1'b0;
            cidx_reg         <= 4'd0;
            out_valid_reg    <= 1'b0;
            prev_left_reg    <= 32'sd0;
            prev_right_reg   <= 32'sd0;
            prev_stamp_reg   <= 63'd0;
            pose_x_reg       <= 32'd0;
            pose_y_reg       <= 32'd0;
            pose_heading_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                step_reg       <= ddo_pkg::ST_RPM_CPR;
                crun_reg       <= 1'b1;
                cidx_reg       <= 4'd0;
                prev_left_reg  <= left_count;
                prev_right_reg <= right_count;
                prev_stamp_reg <= timestamp_ns;
            end
            else if (crun_reg)
            begin
                cidx_reg <= cidx_reg + 4'd1;
                if (cidx_reg == 4'd15)
                    crun_reg <= 1'b0;
            end

            if (state_reg == ddo_pkg::S_SETUP)
                cnt_reg <= (op_w == ddo_pkg::OP_DIV) ? 7'd127 : 7'd63;
            else if (state_reg == ddo_pkg::S_RUN)
                cnt_reg <= cnt_reg - 7'd1;

            if (state_reg == ddo_pkg::S_POST)
            begin
                if (step_reg != ddo_pkg::ST_PY)
                    step_reg <= ddo_pkg::step_t'(step_reg + 5'd1);
                unique case (step_reg)
                    ddo_pkg::ST_H_CPR:
                        pose_heading_reg <= diff_neg_reg ? pose_heading_reg - res_w[15:0]
                                                         : pose_heading_reg + res_w[15:0];
                    ddo_pkg::ST_PX: pose_x_reg <= pose_x_reg + prod_sh[31:0];
                    ddo_pkg::ST_PY: pose_y_reg <= pose_y_reg + prod_sh[31:0];
                    default: ;
                endcase
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dl_mag_reg   <= dl_w[32] ? (~dl_w + 33'd1) : dl_w;
            dr_mag_reg   <= dr_w[32] ? (~dr_w + 33'd1) : dr_w;
            sum_mag_reg  <= sum_w[33] ? (~sum_w + 34'd1) : sum_w;
            diff_mag_reg <= diff_w[33] ? (~diff_w + 34'd1) : diff_w;
            sum_neg_reg  <= sum_w[33];
            diff_neg_reg <= diff_w[33];
            dt_reg       <= timestamp_ns - prev_stamp_reg;
            zero_reg     <= zero_w;
            over_reg     <= 1'b0;
            vx_reg       <= 32'd0;
            vy_reg       <= 32'd0;
            turn_reg     <= 32'd0;
        end

        unique case (state_reg)
            ddo_pkg::S_SETUP:
            begin
                xop_reg <= x_w;
                dop_reg <= y_w;
                rem_reg <= 64'd0;
                // a compare keeps the product in acc
                if (op_w == ddo_pkg::OP_DIV)
                    mq_reg <= x_w;
                else if (op_w == ddo_pkg::OP_MUL)
                begin
                    mq_reg  <= {64'd0, y_w};
                    acc_reg <= 128'd0;
                end
            end
            ddo_pkg::S_RUN:
            begin
                if (op_w == ddo_pkg::OP_DIV)
                begin
                    rem_reg <= div_ge ? add_sum[63:0] : {rem_reg[62:0], mq_reg[127]};
                    mq_reg  <= {mq_reg[126:0], div_ge};
                end
                else
                begin
                    acc_reg <= add_sum[127:0];
                    mq_reg  <= {mq_reg[126:0], 1'b0};
                end
            end
            ddo_pkg::S_POST:
            begin
                // keep the last result in acc for the next step
                if (op_w == ddo_pkg::OP_DIV)
                    acc_reg <= mq_reg;
                unique case (step_reg)
                    ddo_pkg::ST_LIM:     lim_reg    <= res_w;
                    ddo_pkg::ST_CMP_L,
                    ddo_pkg::ST_CMP_R:   over_reg   <= over_reg | add_sum[128];
                    ddo_pkg::ST_BASE1:   base_reg   <= res_w;
                    ddo_pkg::ST_DS:      ds_mag_reg <= clamp33_w;
                    ddo_pkg::ST_V_DT:    v_mag_reg  <= clamp33_w;
                    ddo_pkg::ST_WS_DIFF: wd_reg     <= res_w;
                    ddo_pkg::ST_T_DT:    turn_reg   <= turn_w;
                    ddo_pkg::ST_VX:      vx_reg     <= prod_sat;
                    ddo_pkg::ST_VY:      vy_reg     <= prod_sat;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (load_out)
        begin
            out_pos_x_reg   <= pose_x_reg;
            out_pos_y_reg   <= pose_y_reg;
            out_heading_reg <= pose_heading_reg;
            out_vel_x_reg   <= vx_reg;
            out_vel_y_reg   <= vy_reg;
            out_turn_reg    <= turn_reg;
            out_over_reg    <= over_reg;
            out_zero_reg    <= zero_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = out_pos_x_reg;
    assign pos_y         = out_pos_y_reg;
    assign heading       = out_heading_reg;
    assign vel_x         = out_vel_x_reg;
    assign vel_y         = out_vel_y_reg;
    assign turn_rate     = out_turn_reg;
    assign overspeed     = out_over_reg;
    assign zero_interval = out_zero_reg;

endmodule

`default_nettype wire
